>>> src/tpbm_pkg.sv
// tpbm_pkg: shared types and constants for the two-port bus merge
// no dependencies
package tpbm_pkg;

  localparam int unsigned CtlW      = 6;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned DataW     = 32;
  localparam int unsigned MaskW     = 4;
  localparam int unsigned AdW       = AddrW + DataW;
  localparam int unsigned FlagsW    = 2;

  localparam int unsigned CtlValidBit = 0;
  localparam int unsigned CtlReadBit  = 1;
  localparam int unsigned CtlMaskLsb  = 2;

  localparam logic IdFetch = 1'b0;
  localparam logic IdLdst  = 1'b1;

  typedef struct packed {
    logic valid;
    logic sel;
    logic rd;
    logic push;
    logic cur_id;
  } arb_t;

  typedef struct packed {
    logic head_id;
    logic full;
    logic empty_seen;
  } idq_t;

endpackage

>>> src/tpbm_ram.sv
// tpbm_ram: generic single-write, single-read ram with registered read
// no dependencies
module tpbm_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tpbm_arb.sv
// tpbm_arb: two-way round-robin arbiter with last-winner register
// depends on tpbm_pkg
module tpbm_arb (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        fetch_valid_i,
  input  logic                        ldst_valid_i,
  input  logic                        fetch_read_i,
  input  logic                        ldst_read_i,
  input  logic                        bus_cmd_ready_i,
  output tpbm_pkg::arb_t              arb_o
);
  import tpbm_pkg::*;

  logic last_q, last_d;
  logic sel;
  logic push;

  always_comb begin
    if (fetch_valid_i && !ldst_valid_i) begin
      sel = IdFetch;
    end else if (fetch_valid_i && ldst_valid_i) begin
      sel = ~last_q;
    end else if (!fetch_valid_i && !ldst_valid_i) begin
      sel = last_q;
    end else begin
      sel = IdLdst;
    end
  end

  assign push   = (fetch_valid_i | ldst_valid_i) & bus_cmd_ready_i;
  assign last_d = push ? sel : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= IdFetch;
    end else if (en_i) begin
      last_q <= last_d;
    end
  end

  assign arb_o.valid  = fetch_valid_i | ldst_valid_i;
  assign arb_o.sel    = sel;
  assign arb_o.rd     = (sel == IdLdst) ? ldst_read_i : fetch_read_i;
  assign arb_o.push   = push;
  assign arb_o.cur_id = last_d;

endmodule

>>> src/tpbm_idq.sv
// tpbm_idq: response id ring, pointers in flops, ids in a ram
// depends on tpbm_pkg and tpbm_ram
module tpbm_idq #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           push_i,
  input  logic           push_id_i,
  input  logic           pop_i,
  output tpbm_pkg::idq_t stat_o
);
  import tpbm_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW-1:0] wnext, rnext;
  logic            empty_seen_q, empty_seen_d;
  logic            we;
  logic            ram_rdata;
  logic            fwd_q, fwd_data_q;

  assign wnext = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
  assign rnext = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;

  assign we           = en_i & push_i;
  assign wptr_d       = we ? wnext : wptr_q;
  assign rptr_d       = (en_i & pop_i) ? rnext : rptr_q;
  assign empty_seen_d = (wptr_q == rptr_q) & pop_i & ~push_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q       <= '0;
      rptr_q       <= '0;
      empty_seen_q <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fwd_q  <= we && (wptr_q == rptr_d);
      if (en_i) begin
        empty_seen_q <= empty_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_id_i;
  end

  // ram reads at the next read pointer, so its registered output is already the head
  tpbm_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (push_id_i),
    .raddr_i (rptr_d),
    .rdata_o (ram_rdata)
  );

  assign stat_o.head_id    = fwd_q ? fwd_data_q : ram_rdata;
  assign stat_o.full       = (wnext == rptr_q);
  assign stat_o.empty_seen = empty_seen_q;

endmodule

>>> src/two_port_bus_merge_rr_top.sv
// two_port_bus_merge_rr_top: round-robin merge of fetch and load/store onto one bus
// output: each input transfer is captured directly into the output registers
// throughput: one item per cycle unless the output stalls; the id ring ram reads ahead at the next head
// reset: asynchronous active low; clears arbiter, pointers and output valid
// ring entries hold no reset and are defined once written
// depends on tpbm_pkg, tpbm_arb, tpbm_idq, tpbm_ram
module two_port_bus_merge_rr_top #(
  parameter int unsigned ID_FIFO_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tpbm_pkg::CtlW-1:0]     fetch_cmd_ctl_i,
  input  logic [tpbm_pkg::AdW-1:0]      fetch_addr_data_i,
  input  logic [tpbm_pkg::CtlW-1:0]     ldst_cmd_ctl_i,
  input  logic [tpbm_pkg::AdW-1:0]      ldst_addr_data_i,
  input  logic                          bus_cmd_ready_i,
  input  logic                          bus_rsp_valid_i,
  input  logic                          bus_rsp_is_read_i,
  input  logic [tpbm_pkg::DataW-1:0]    bus_rsp_rdata_i,
  input  logic                          fetch_rsp_ready_i,
  input  logic                          ldst_rsp_ready_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          merged_valid_o,
  output logic                          merged_read_o,
  output logic [tpbm_pkg::AddrW-1:0]    merged_addr_o,
  output logic [tpbm_pkg::DataW-1:0]    merged_wdata_o,
  output logic [tpbm_pkg::MaskW-1:0]    merged_mask_o,
  output logic                          fetch_cmd_ready_o,
  output logic                          ldst_cmd_ready_o,
  output logic [tpbm_pkg::FlagsW-1:0]   fetch_rsp_flags_o,
  output logic [tpbm_pkg::FlagsW-1:0]   ldst_rsp_flags_o,
  output logic [tpbm_pkg::DataW-1:0]    rsp_rdata_o,
  output logic                          bus_rsp_ready_o,
  output logic                          id_fifo_full_o
);
  import tpbm_pkg::*;

  logic              in_xfer;
  arb_t              arb;
  idq_t              idq;
  logic [CtlW-1:0]   win_ctl;
  logic [AdW-1:0]    win_ad;
  logic              rid;
  logic              rsp_rdy;
  logic              pop;
  logic [FlagsW-1:0] rsp_flags;

  logic              out_valid_q;
  logic              merged_valid_q, merged_read_q;
  logic [AddrW-1:0]  merged_addr_q;
  logic [DataW-1:0]  merged_wdata_q;
  logic [MaskW-1:0]  merged_mask_q;
  logic              fetch_cmd_ready_q, ldst_cmd_ready_q;
  logic [FlagsW-1:0] fetch_rsp_flags_q, ldst_rsp_flags_q;
  logic [DataW-1:0]  rsp_rdata_q;
  logic              bus_rsp_ready_q, id_fifo_full_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  tpbm_arb u_arb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (in_xfer),
    .fetch_valid_i   (fetch_cmd_ctl_i[CtlValidBit]),
    .ldst_valid_i    (ldst_cmd_ctl_i[CtlValidBit]),
    .fetch_read_i    (fetch_cmd_ctl_i[CtlReadBit]),
    .ldst_read_i     (ldst_cmd_ctl_i[CtlReadBit]),
    .bus_cmd_ready_i (bus_cmd_ready_i),
    .arb_o           (arb)
  );

  assign win_ctl = (arb.sel == IdLdst) ? ldst_cmd_ctl_i : fetch_cmd_ctl_i;
  assign win_ad  = (arb.sel == IdLdst) ? ldst_addr_data_i : fetch_addr_data_i;

  // write with ring marked empty routes by the current id
  assign rid       = (arb.valid & ~arb.rd & idq.empty_seen) ? arb.cur_id : idq.head_id;
  assign rsp_rdy   = (rid == IdLdst) ? ldst_rsp_ready_i : fetch_rsp_ready_i;
  assign pop       = bus_rsp_valid_i & rsp_rdy;
  assign rsp_flags = {bus_rsp_is_read_i, bus_rsp_valid_i};

  tpbm_idq #(
    .Depth (ID_FIFO_DEPTH)
  ) u_idq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (in_xfer),
    .push_i    (arb.push),
    .push_id_i (arb.cur_id),
    .pop_i     (pop),
    .stat_o    (idq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      merged_valid_q    <= arb.valid;
      merged_read_q     <= arb.rd;
      merged_addr_q     <= win_ad[AddrW-1:0];
      merged_wdata_q    <= win_ad[AdW-1:AddrW];
      merged_mask_q     <= win_ctl[CtlMaskLsb +: MaskW];
      fetch_cmd_ready_q <= (arb.sel == IdFetch) & bus_cmd_ready_i;
      ldst_cmd_ready_q  <= (arb.sel == IdLdst) & bus_cmd_ready_i;
      fetch_rsp_flags_q <= (rid == IdFetch) ? rsp_flags : '0;
      ldst_rsp_flags_q  <= (rid == IdLdst) ? rsp_flags : '0;
      rsp_rdata_q       <= bus_rsp_rdata_i;
      bus_rsp_ready_q   <= rsp_rdy;
      id_fifo_full_q    <= idq.full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign merged_valid_o    = merged_valid_q;
  assign merged_read_o     = merged_read_q;
  assign merged_addr_o     = merged_addr_q;
  assign merged_wdata_o    = merged_wdata_q;
  assign merged_mask_o     = merged_mask_q;
  assign fetch_cmd_ready_o = fetch_cmd_ready_q;
  assign ldst_cmd_ready_o  = ldst_cmd_ready_q;
  assign fetch_rsp_flags_o = fetch_rsp_flags_q;
  assign ldst_rsp_flags_o  = ldst_rsp_flags_q;
  assign rsp_rdata_o       = rsp_rdata_q;
  assign bus_rsp_ready_o   = bus_rsp_ready_q;
  assign id_fifo_full_o    = id_fifo_full_q;

  a_rsp_one_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(fetch_rsp_flags_q[0] && ldst_rsp_flags_q[0]))
    else $error("response routed to both requesters");

  a_cmd_one_winner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(fetch_cmd_ready_q && ldst_cmd_ready_q))
    else $error("both command readies high");

  a_xfer_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted item produced no result");

  a_lone_valid_wins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && fetch_cmd_ctl_i[CtlValidBit] && !ldst_cmd_ctl_i[CtlValidBit])
      |-> (arb.sel == IdFetch))
    else $error("lone fetch request lost arbitration");

endmodule
